/* hw/rtl/fbte_pkg.sv */
// ----------------------------------------------------------------------------
// fbte_pkg
// Shared types, operation codes and the 5x7 font table of the framebuffer
// text engine.
// ----------------------------------------------------------------------------
package fbte_pkg;

    // Default display size in pixels.
    localparam int DEF_WIDTH  = 128;
    localparam int DEF_HEIGHT = 64;

    // Operation codes carried in the kind field.
    localparam logic [2:0] KIND_CLEAR = 3'd0;
    localparam logic [2:0] KIND_SET   = 3'd1;
    localparam logic [2:0] KIND_RESET = 3'd2;
    localparam logic [2:0] KIND_GLYPH = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    // Printable character range covered by the font.
    localparam logic [7:0] GLYPH_FIRST = 8'd32;
    localparam logic [7:0] GLYPH_LAST  = 8'd126;
    localparam int         GLYPH_CNT   = 95;
    localparam int         GLYPH_COLS  = 5;

    // Decoded command passed from the front end to the execution unit.
    // For pixel and read operations col and row are already clamped.
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [39:0] glyph;
    } t_cmd;

    // Font table: one row per character, column 0 in the top byte.
    localparam logic [39:0] GLYPH_ROM [GLYPH_CNT] = '{
        40'h0000000000, 40'h00002F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0040300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141494F31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0036360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h417F410000, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F2018207F, 40'h7F300E017F, 40'h3E4141413E,
        40'h7F1111110E, 40'h3E4151215E, 40'h7F1111314E, 40'h3249494926,
        40'h01017F0101, 40'h3F4040403F, 40'h070870_0807, 40'h3F4038403F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F44444438, 40'h3844444428,
        40'h384444447F, 40'h3854545418, 40'h087E090102, 40'h18A4A4A47C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F08142241,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'hFC24242418, 40'h18242424FC, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h7C4040207C, 40'h0E1020100E, 40'h7C2018207C,
        40'h6C10106C00, 40'h6C10100E00, 40'h4C54545464, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h0C52527C00
    };

endpackage

/* hw/rtl/fbte_front.sv */
// ----------------------------------------------------------------------------
// fbte_front
// Accepts input transactions, clamps pixel coordinates, looks up the glyph
// and pushes one decoded command into the command queue.
// ----------------------------------------------------------------------------
module fbte_front #(
    parameter int DISPLAY_WIDTH  = fbte_pkg::DEF_WIDTH,
    parameter int DISPLAY_HEIGHT = fbte_pkg::DEF_HEIGHT
) (
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [2:0]     i_kind,
    input  logic [7:0]     i_x,
    input  logic [7:0]     i_y,
    input  logic [7:0]     i_char_code,
    input  logic           i_q_full,
    input  logic           i_init_busy,
    output logic           o_push,
    output fbte_pkg::t_cmd o_cmd
);
    import fbte_pkg::*;

    logic [7:0] cx;
    logic [7:0] cy;
    logic [6:0] gidx;
    logic       code_ok;

    // Clamp coordinates for pixel operations and reads.
    always_comb begin
        cx = ({1'b0, i_x} >= 9'(DISPLAY_WIDTH))  ? 8'(DISPLAY_WIDTH - 1)  : i_x;
        cy = ({1'b0, i_y} >= 9'(DISPLAY_HEIGHT)) ? 8'(DISPLAY_HEIGHT - 1) : i_y;
    end

    // Unprintable codes fall back to the space glyph.
    always_comb begin
        code_ok = (i_char_code >= GLYPH_FIRST) && (i_char_code <= GLYPH_LAST);
        gidx    = code_ok ? 7'(i_char_code - GLYPH_FIRST) : 7'd0;
    end

    // Build the command; glyphs keep their raw position.
    always_comb begin
        o_cmd.kind  = i_kind;
        o_cmd.col   = (i_kind == KIND_GLYPH) ? i_x : cx;
        o_cmd.row   = (i_kind == KIND_GLYPH) ? i_y : cy;
        o_cmd.glyph = GLYPH_ROM[gidx];
    end

    // Hold off while the queue is full or the store is being cleared after reset.
    assign o_in_stall = i_q_full || i_init_busy;
    assign o_push     = i_in_valid && !o_in_stall;

endmodule

/* hw/rtl/fbte_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// fbte_cmd_fifo
// Two-entry command queue between the front end and the execution unit.
// ----------------------------------------------------------------------------
module fbte_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fbte_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output fbte_pkg::t_cmd o_cmd,
    output logic           o_full,
    output logic           o_empty
);
    import fbte_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    // Occupancy tracking.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    // Storage slots need no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd   = r_slot[r_rd_ptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

endmodule

/* hw/rtl/fbte_back.sv */
// ----------------------------------------------------------------------------
// fbte_back
// Execution unit: owns the framebuffer memory, runs read-modify-write
// sequences for pixels and glyphs, sweeps the store on clear and holds the
// result register.
// ----------------------------------------------------------------------------
module fbte_back #(
    parameter int DISPLAY_WIDTH  = fbte_pkg::DEF_WIDTH,
    parameter int DISPLAY_HEIGHT = fbte_pkg::DEF_HEIGHT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fbte_pkg::t_cmd i_cmd,
    input  logic           i_q_empty,
    output logic           o_pop,
    output logic           o_init_busy,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_read_data
);
    import fbte_pkg::*;

    localparam int PAGES = (DISPLAY_HEIGHT + 7) / 8;
    localparam int DEPTH = DISPLAY_WIDTH * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int LAST_STEP = 2 * GLYPH_COLS - 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CLR  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rdata;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic          r_init;
    logic [AW-1:0] r_clr_addr;
    logic [3:0]    r_step;
    t_cmd          r_cmd;

    logic          r_pend_valid;
    logic          r_pend_and;
    logic [AW-1:0] r_pend_addr;
    logic [7:0]    r_pend_bits;

    logic          r_out_valid;
    logic [7:0]    r_out_data;

    logic [2:0]    gcol;
    logic          part;
    logic [8:0]    col9;
    logic [5:0]    page6;
    logic [39:0]   glyph_sh;
    logic [15:0]   wide;
    logic [7:0]    bits;
    logic          acc_ok;
    logic [AW-1:0] acc_addr;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    // Address and bit pattern for the current access step.
    always_comb begin
        gcol     = r_step[3:1];
        part     = r_step[0];
        glyph_sh = r_cmd.glyph << {gcol, 3'b000};
        wide     = {8'd0, glyph_sh[39:32]} << r_cmd.row[2:0];
        if (r_cmd.kind == KIND_GLYPH) begin
            col9   = {1'b0, r_cmd.col} + 9'(gcol);
            page6  = {1'b0, r_cmd.row[7:3]} + 6'(part);
            bits   = part ? wide[15:8] : wide[7:0];
            acc_ok = (col9 < 9'(DISPLAY_WIDTH)) && (page6 < 6'(PAGES))
                     && !(part && (r_cmd.row[2:0] == 3'd0));
        end else begin
            col9   = {1'b0, r_cmd.col};
            page6  = {1'b0, r_cmd.row[7:3]};
            bits   = 8'd1 << r_cmd.row[2:0];
            acc_ok = 1'b1;
        end
        acc_addr = AW'(int'(col9) + DISPLAY_WIDTH * int'(page6));
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty && !r_out_valid) begin
                    o_pop = 1'b1;
                    if (i_cmd.kind == KIND_CLEAR) begin
                        n_state = S_CLR;
                    end else if (i_cmd.kind == KIND_SET || i_cmd.kind == KIND_RESET
                                 || i_cmd.kind == KIND_GLYPH || i_cmd.kind == KIND_READ) begin
                        n_state = S_EXEC;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_CLR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = r_init ? S_IDLE : S_DONE;
                end
            end
            S_EXEC: begin
                if (r_cmd.kind != KIND_GLYPH || r_step == 4'(LAST_STEP)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_init       <= 1'b1;
            r_clr_addr   <= '0;
            r_step       <= 4'd0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= (r_state == S_EXEC) && acc_ok && (r_cmd.kind != KIND_READ);
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clr_addr <= '0;
                    r_init     <= 1'b0;
                end
            end
            if (r_state == S_EXEC) begin
                r_step <= r_step + 4'd1;
            end else begin
                r_step <= 4'd0;
            end
            if (r_state == S_DONE) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_EXEC) begin
            r_pend_addr <= acc_addr;
            r_pend_bits <= bits;
            r_pend_and  <= (r_cmd.kind == KIND_RESET);
        end
        if (r_state == S_DONE) begin
            r_out_data <= (r_cmd.kind == KIND_READ) ? r_rdata : 8'd0;
        end
    end

    // Memory port control: a read in each in-range step and, except for reads, its write in the next cycle.
    always_comb begin
        rd_en   = (r_state == S_EXEC) && acc_ok;
        wr_en   = (r_state == S_CLR) || r_pend_valid;
        wr_addr = (r_state == S_CLR) ? r_clr_addr : r_pend_addr;
        if (r_state == S_CLR) begin
            wr_data = 8'd0;
        end else if (r_pend_and) begin
            wr_data = r_rdata & ~r_pend_bits;
        end else begin
            wr_data = r_rdata | r_pend_bits;
        end
    end

    // Framebuffer memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[acc_addr];
        end
    end

    assign o_init_busy = r_init;
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

endmodule

/* hw/rtl/mono_page_framebuffer_text_engine_unit.sv */
// ----------------------------------------------------------------------------
// mono_page_framebuffer_text_engine_unit
// Monochrome page framebuffer with a 5x7 text engine.
// ----------------------------------------------------------------------------
// Each transaction clears the store, sets or clears a pixel, ORs a font glyph
// into the store or reads one byte back (unused kinds do nothing), and every
// transaction returns one result byte. The front end decodes and queues up to
// two commands while the execution unit works; one command runs at a time on a
// single framebuffer memory with one read and one write port. A pixel or read
// is a single memory step, a glyph ten read-modify-write steps pipelined over
// the memory ports, and a clear sweeps the DISPLAY_WIDTH x
// ceil(DISPLAY_HEIGHT/8) bytes of the store one byte a cycle. After reset the
// same sweep runs once with the input stalled.
module mono_page_framebuffer_text_engine_unit #(
    parameter int DISPLAY_WIDTH  = fbte_pkg::DEF_WIDTH,
    parameter int DISPLAY_HEIGHT = fbte_pkg::DEF_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_kind,
    input  logic [7:0] i_x,
    input  logic [7:0] i_y,
    input  logic [7:0] i_char_code,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_data
);
    import fbte_pkg::*;

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    logic init_busy;

    // Decode stage.
    fbte_front #(
        .DISPLAY_WIDTH (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_x        (i_x),
        .i_y        (i_y),
        .i_char_code(i_char_code),
        .i_q_full   (q_full),
        .i_init_busy(init_busy),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    // Command queue.
    fbte_cmd_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (front_cmd),
        .i_pop  (pop),
        .o_cmd  (q_cmd),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    // Execution unit and framebuffer.
    fbte_back #(
        .DISPLAY_WIDTH (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (q_cmd),
        .i_q_empty  (q_empty),
        .o_pop      (pop),
        .o_init_busy(init_busy),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_read_data(o_read_data)
    );

endmodule

/* hw/rtl/fbte_checker.sv */
// ----------------------------------------------------------------------------
// fbte_checker
// Port-level checks of the framebuffer text engine, bound to the top level.
// ----------------------------------------------------------------------------
module fbte_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_stall,
    input logic       i_out_valid,
    input logic       i_out_stall,
    input logic [7:0] i_read_data
);

    // A stalled result stays and keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_read_data))
        else $error("result changed while stalled");

    // The store is swept after reset, so no transaction is taken right away.
    a_init_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_stall)
        else $error("input not stalled after reset");

    // No result is offered right after reset.
    a_init_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind mono_page_framebuffer_text_engine_unit fbte_checker u_fbte_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_stall (o_in_stall),
    .i_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .i_read_data(o_read_data)
);

/* tb/sv/mono_page_framebuffer_text_engine_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_page_framebuffer_text_engine_checker
// Watches both channels of the framebuffer text engine, keeps a shadow copy
// of the page store, predicts each result byte and compares it in order.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_text_engine_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [2:0] i_kind,
    input  logic [7:0] i_x,
    input  logic [7:0] i_y,
    input  logic [7:0] i_char_code,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_read_data,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_in_count,
    output int         o_out_count
);
    import fbte_pkg::*;

    localparam int WIDTH = DEF_WIDTH;
    localparam int HEIGHT = DEF_HEIGHT;
    localparam int PAGES = (HEIGHT + 7) / 8;

    logic [7:0] shadow_store [WIDTH * PAGES];
    logic [7:0] expected_bytes [$];

    // Font lookup written as its own table, column 0 first.
    function automatic logic [7:0] font_column(input logic [7:0] code, input int c);
        logic [39:0] row;
        logic [7:0] idx;
        begin
            idx = (code < GLYPH_FIRST || code > GLYPH_LAST) ? 8'd0 : code - GLYPH_FIRST;
            case (idx)
                0: row = 40'h0000000000;  1: row = 40'h00002F0000;  2: row = 40'h0007000700;
                3: row = 40'h147F147F14;  4: row = 40'h242A7F2A12;  5: row = 40'h2313086462;
                6: row = 40'h3649552250;  7: row = 40'h0005030000;  8: row = 40'h001C224100;
                9: row = 40'h0041221C00; 10: row = 40'h14083E0814; 11: row = 40'h08083E0808;
                12: row = 40'h0040300000; 13: row = 40'h0808080808; 14: row = 40'h0060600000;
                15: row = 40'h2010080402; 16: row = 40'h3E5149453E; 17: row = 40'h00427F4000;
                18: row = 40'h4261514946; 19: row = 40'h2141494F31; 20: row = 40'h1814127F10;
                21: row = 40'h2745454539; 22: row = 40'h3C4A494930; 23: row = 40'h0171090503;
                24: row = 40'h3649494936; 25: row = 40'h064949291E; 26: row = 40'h0036360000;
                27: row = 40'h0036360000; 28: row = 40'h0814224100; 29: row = 40'h1414141414;
                30: row = 40'h0041221408; 31: row = 40'h0201510906; 32: row = 40'h324979413E;
                33: row = 40'h7E1111117E; 34: row = 40'h7F49494936; 35: row = 40'h3E41414122;
                36: row = 40'h7F4141221C; 37: row = 40'h7F49494941; 38: row = 40'h7F09090901;
                39: row = 40'h3E4149497A; 40: row = 40'h7F0808087F; 41: row = 40'h417F410000;
                42: row = 40'h2040413F01; 43: row = 40'h7F08142241; 44: row = 40'h7F40404040;
                45: row = 40'h7F2018207F; 46: row = 40'h7F300E017F; 47: row = 40'h3E4141413E;
                48: row = 40'h7F1111110E; 49: row = 40'h3E4151215E; 50: row = 40'h7F1111314E;
                51: row = 40'h3249494926; 52: row = 40'h01017F0101; 53: row = 40'h3F4040403F;
                54: row = 40'h0708700807; 55: row = 40'h3F4038403F; 56: row = 40'h6314081463;
                57: row = 40'h0304780403; 58: row = 40'h6151494543; 59: row = 40'h007F414100;
                60: row = 40'h0204081020; 61: row = 40'h0041417F00; 62: row = 40'h0402010204;
                63: row = 40'h4040404040; 64: row = 40'h0001020400; 65: row = 40'h2054545478;
                66: row = 40'h7F44444438; 67: row = 40'h3844444428; 68: row = 40'h384444447F;
                69: row = 40'h3854545418; 70: row = 40'h087E090102; 71: row = 40'h18A4A4A47C;
                72: row = 40'h7F08040478; 73: row = 40'h00447D4000; 74: row = 40'h2040443D00;
                75: row = 40'h7F08142241; 76: row = 40'h00417F4000; 77: row = 40'h7C04180478;
                78: row = 40'h7C08040478; 79: row = 40'h3844444438; 80: row = 40'hFC24242418;
                81: row = 40'h18242424FC; 82: row = 40'h7C08040408; 83: row = 40'h4854545420;
                84: row = 40'h043F444020; 85: row = 40'h7C4040207C; 86: row = 40'h0E1020100E;
                87: row = 40'h7C2018207C; 88: row = 40'h6C10106C00; 89: row = 40'h6C10100E00;
                90: row = 40'h4C54545464; 91: row = 40'h0008364100; 92: row = 40'h00007F0000;
                93: row = 40'h0041360800; 94: row = 40'h0C52527C00;
                default: row = 40'h0;
            endcase
            font_column = row[39 - 8 * c -: 8];
        end
    endfunction

    // Applies one command to the shadow store and returns its result byte.
    function automatic logic [7:0] apply_command(input logic [2:0] kind, input logic [7:0] x,
                                                 input logic [7:0] y, input logic [7:0] code);
        int cx, cy, addr, col, page, sh;
        logic [15:0] wide;
        logic [7:0] res;
        begin
            res = 8'h00;
            cx = (x >= WIDTH) ? WIDTH - 1 : x;
            cy = (y >= HEIGHT) ? HEIGHT - 1 : y;
            addr = cx + WIDTH * (cy / 8);
            case (kind)
                KIND_CLEAR: for (int i = 0; i < WIDTH * PAGES; i++) shadow_store[i] = 8'h00;
                KIND_SET:   shadow_store[addr] |= 8'(1 << (cy % 8));
                KIND_RESET: shadow_store[addr] &= ~8'(1 << (cy % 8));
                KIND_GLYPH: begin
                    sh = y % 8;
                    page = y / 8;
                    for (int c = 0; c < GLYPH_COLS; c++) begin
                        col = x + c;
                        wide = {8'h00, font_column(code, c)} << sh;
                        if (col < WIDTH && page < PAGES)
                            shadow_store[col + WIDTH * page] |= wide[7:0];
                        if (sh != 0 && col < WIDTH && page + 1 < PAGES)
                            shadow_store[col + WIDTH * (page + 1)] |= wide[15:8];
                    end
                end
                KIND_READ:  res = shadow_store[addr];
                default:    res = 8'h00;
            endcase
            apply_command = res;
        end
    endfunction

    initial begin
        for (int i = 0; i < WIDTH * PAGES; i++) shadow_store[i] = 8'h00;
    end

    assign o_pending = expected_bytes.size();

    // Predict on accepted inputs and check accepted outputs.
    always @(posedge i_clk) begin
        logic [7:0] want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_in_count <= 0;
            o_out_count <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_bytes.push_back(apply_command(i_kind, i_x, i_y, i_char_code));
                o_in_count <= o_in_count + 1;
            end
            if (i_out_valid && !i_out_stall) begin
                o_out_count <= o_out_count + 1;
                if (expected_bytes.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result transaction: read_data %02h", i_read_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_bytes.pop_front();
                    if (want !== i_read_data) begin
                        if (o_fail_count < 10)
                            $display("read_data mismatch: expected %02h actual %02h",
                                     want, i_read_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* tb/sv/mono_page_framebuffer_text_engine_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_page_framebuffer_text_engine_unit_test
// Drives directed and random framebuffer commands through the text engine
// under several idling phases and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_text_engine_unit_test;
    import fbte_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [2:0] i_kind = 3'd0;
    logic [7:0] i_x = 8'd0;
    logic [7:0] i_y = 8'd0;
    logic [7:0] i_char_code = 8'd0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall, o_out_valid;
    logic [7:0] o_read_data;
    int         fail_count, pending, in_count, out_count;
    int         send_idle_pct = 0, stall_pct = 0;
    bit         hold_off = 1'b0;
    int         idle_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    mono_page_framebuffer_text_engine_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_kind(i_kind), .i_x(i_x), .i_y(i_y), .i_char_code(i_char_code),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_read_data(o_read_data)
    );

    mono_page_framebuffer_text_engine_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_kind(i_kind), .i_x(i_x), .i_y(i_y), .i_char_code(i_char_code),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_read_data(o_read_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_in_count(in_count),
        .o_out_count(out_count)
    );

    // Receiver stall: random by phase, or held for a long stretch.
    always @(posedge i_clk) begin
        if (hold_off) i_out_stall <= 1'b1;
        else i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired: %0d pending", pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offers one command and waits until it is accepted. Valid stays high
    // afterwards so that back-to-back commands need no gap; the caller drops
    // it after the last command.
    task automatic send_command(input logic [2:0] kind, input logic [7:0] x,
                                input logic [7:0] y, input logic [7:0] code);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_x <= x;
        i_y <= y;
        i_char_code <= code;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Mostly reads, pixel work and glyphs inside the display, some noise, clears and unused kinds.
    task automatic random_command();
        int pick;
        logic [7:0] px, py;
        pick = $urandom_range(99);
        px = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(127));
        py = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(63));
        if (pick < 1) send_command(KIND_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
        else if (pick < 20) send_command(KIND_SET, px, py, 8'($urandom));
        else if (pick < 30) send_command(KIND_RESET, px, py, 8'($urandom));
        else if (pick < 55) send_command(KIND_GLYPH, px, py,
                                         ($urandom_range(9) == 0) ? 8'($urandom)
                                                                  : 8'($urandom_range(32, 126)));
        else if (pick < 97) send_command(KIND_READ, px, py, 8'($urandom));
        else send_command(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: edges, every kind, clamping, out-of-range codes and glyph spill.
        send_command(KIND_SET, 8'd0, 8'd0, 8'd0);
        send_command(KIND_SET, 8'd255, 8'd255, 8'd0);
        send_command(KIND_READ, 8'd200, 8'd100, 8'd0);
        send_command(KIND_READ, 8'd0, 8'd0, 8'd0);
        send_command(KIND_RESET, 8'd130, 8'd70, 8'd0);
        send_command(KIND_READ, 8'd127, 8'd63, 8'd0);
        send_command(KIND_GLYPH, 8'd10, 8'd3, 8'd65);
        send_command(KIND_READ, 8'd10, 8'd0, 8'd0);
        send_command(KIND_READ, 8'd10, 8'd8, 8'd0);
        send_command(KIND_GLYPH, 8'd125, 8'd60, 8'd126);
        send_command(KIND_READ, 8'd125, 8'd63, 8'd0);
        send_command(KIND_GLYPH, 8'd250, 8'd250, 8'd88);
        send_command(KIND_GLYPH, 8'd40, 8'd16, 8'd31);
        send_command(KIND_GLYPH, 8'd40, 8'd16, 8'd127);
        send_command(KIND_GLYPH, 8'd40, 8'd16, 8'd255);
        send_command(KIND_READ, 8'd41, 8'd16, 8'd0);
        send_command(3'd5, 8'd1, 8'd1, 8'd1);
        send_command(3'd6, 8'd255, 8'd255, 8'd255);
        send_command(3'd7, 8'd0, 8'd0, 8'd0);
        send_command(KIND_CLEAR, 8'd0, 8'd0, 8'd0);
        send_command(KIND_READ, 8'd10, 8'd0, 8'd0);
        send_command(KIND_READ, 8'd0, 8'd0, 8'd0);

        // Random phases with different idling on both sides.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 61 : 38) : 0;
            stall_pct = (phase == 2) ? 61 : (phase == 3 ? 38 : 0);
            for (int n = 0; n < 280; n++) random_command();
        end

        // Long receiver hold-off while commands keep coming, filling the block.
        send_idle_pct = 0;
        stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 10; n++) random_command();
        join
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
        $display("covered %0d commands and %0d results: pixel, glyph, read, clear, unused",
                 in_count, out_count);
        $display("kinds, clamping, edge spill, four idling phases and a long output hold-off");
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

/* mono_page_framebuffer_text_engine_unit.f */
hw/rtl/fbte_pkg.sv
hw/rtl/fbte_front.sv
hw/rtl/fbte_cmd_fifo.sv
hw/rtl/fbte_back.sv
hw/rtl/mono_page_framebuffer_text_engine_unit.sv
hw/rtl/fbte_checker.sv
tb/sv/mono_page_framebuffer_text_engine_checker.sv
tb/sv/mono_page_framebuffer_text_engine_unit_test.sv
